>>> design/cbp_pkg.sv
// Shared types, constants and saturating helpers for the cascaded balance controller.
`default_nettype none
package cbp_pkg;

    typedef logic signed [65:0] wide_t;

    localparam int ERROR_LIMIT_DEF    = 100;
    localparam int INTEGRAL_LIMIT_DEF = 100;
    localparam int ANGLE_LIMIT_DEF    = 30;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int DT_FRAC   = 24;
    localparam int DIV_MAG_W = 57;
    localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);

    localparam logic [2:0] REG_SPEED_KP    = 3'd0;
    localparam logic [2:0] REG_SPEED_KI    = 3'd1;
    localparam logic [2:0] REG_SPEED_KD    = 3'd2;
    localparam logic [2:0] REG_TILT_KP     = 3'd3;
    localparam logic [2:0] REG_TILT_KI     = 3'd4;
    localparam logic [2:0] REG_TILT_KD     = 3'd5;
    localparam logic [2:0] REG_FILTER      = 3'd6;
    localparam logic [2:0] REG_DRIVE_LIMIT = 3'd7;

    localparam wide_t S32_MAX = wide_t'(64'sd2147483647);
    localparam wide_t S32_MIN = -S32_MAX - wide_t'(1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ANG1, ST_ANG2, ST_EST, ST_FLT1, ST_FLT2,
        ST_SERR, ST_SINT0, ST_SINT, ST_SKP, ST_SKI, ST_SWAIT, ST_SKD,
        ST_TERR, ST_TINT0, ST_TINT, ST_TKP, ST_TKI, ST_TWAIT, ST_TKD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic signed [57:0]   num;
        logic [31:0]          den;
    } div_ctrl_t;

    typedef struct packed {
        logic                 busy;
        logic signed [57:0]   quo;
    } div_stat_t;

    function automatic logic signed [31:0] sat32(input wide_t x);
        wide_t r;
        r = x;
        if (x > S32_MAX)
            r = S32_MAX;
        else if (x < S32_MIN)
            r = S32_MIN;
        return r[31:0];
    endfunction

    function automatic wide_t clip(input wide_t x, input wide_t lim);
        wide_t r;
        r = x;
        if (x > lim)
            r = lim;
        else if (x < -lim)
            r = -lim;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/cascaded_balance_pid.sv
// Top level: sequencer and datapath of the cascaded speed/tilt PID controller.
// One transaction in gives one transaction out. A step runs through a small
// sequencer that feeds one shared 33x33 multiplier with a registered product,
// and one bit-serial divider shared by both loops' derivatives; the two divides
// dominate the step, and both are skipped when the interval is zero. The next
// input is taken once the sequencer is back in idle, which is delayed while the
// previous output transaction is still waiting for m_tready.
// Tilt, wheel, target and drive values are signed fixed point with FRAC_BITS
// fraction bits, saturating; the unsigned interval has DT_FRAC fraction bits.
`default_nettype none
module cascaded_balance_pid #(
    parameter int ERROR_LIMIT    = cbp_pkg::ERROR_LIMIT_DEF,
    parameter int INTEGRAL_LIMIT = cbp_pkg::INTEGRAL_LIMIT_DEF,
    parameter int ANGLE_LIMIT    = cbp_pkg::ANGLE_LIMIT_DEF,
    parameter int FRAC_BITS      = cbp_pkg::FRAC_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wen,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tilt, wheel_left, wheel_right, steer, throttle_cmd, interval
    input  wire logic [159:0] s_tdata,
    // clear_pid
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // drive_left, drive_right, target_tilt
    output logic [95:0]       m_tdata
);
    import cbp_pkg::*;

    localparam wide_t ERR_LIM = wide_t'(ERROR_LIMIT) <<< FRAC_BITS;
    localparam wide_t INT_LIM = wide_t'(INTEGRAL_LIMIT) <<< FRAC_BITS;
    localparam wide_t ANG_LIM = wide_t'(ANGLE_LIMIT) <<< FRAC_BITS;

    state_t state_reg, state_next;

    logic signed [31:0] speed_kp_reg, speed_ki_reg, speed_kd_reg;
    logic signed [31:0] tilt_kp_reg, tilt_ki_reg, tilt_kd_reg;
    logic [15:0]        filter_reg;
    logic [30:0]        drive_limit_reg;

    logic signed [31:0] last_tilt_reg, last_tilt_next;
    logic signed [31:0] lms_reg, lms_next;
    logic signed [31:0] ms_reg, ms_next;
    logic signed [31:0] filt_reg, filt_next;
    logic signed [31:0] si_reg, si_next;
    logic signed [31:0] sle_reg, sle_next;
    logic signed [31:0] ti_reg, ti_next;
    logic signed [31:0] tle_reg, tle_next;

    logic signed [31:0] tilt_reg, tilt_next;
    logic signed [15:0] steer_reg, steer_next;
    logic signed [15:0] thr_reg, thr_next;
    logic [31:0]        dt_reg, dt_next;
    logic signed [32:0] dtilt_reg, dtilt_next;
    logic signed [31:0] est_reg, est_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] target_reg, target_next;
    logic signed [31:0] drive_reg, drive_next;
    wide_t              acc_reg, acc_next;

    logic               out_valid_reg, out_valid_next;
    logic [95:0]        out_data_reg, out_data_next;

    logic signed [32:0] mul_a, mul_b;
    wide_t              prod;
    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;

    wide_t              prod_f, prod_dt, q_sat, st_w;
    logic signed [31:0] in_tilt, in_wl, in_wr;

    assign in_tilt = s_tdata[31:0];
    assign in_wl   = s_tdata[63:32];
    assign in_wr   = s_tdata[95:64];
    assign prod_f  = prod >>> FRAC_BITS;
    assign prod_dt = prod >>> DT_FRAC;
    assign q_sat   = wide_t'(sat32(wide_t'(div_stat.quo)));
    assign st_w    = wide_t'(steer_reg) <<< FRAC_BITS;

    cbp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    cbp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_kp_reg    <= 32'sd1 <<< FRAC_BITS;
            speed_ki_reg    <= '0;
            speed_kd_reg    <= '0;
            tilt_kp_reg     <= 32'sd1 <<< FRAC_BITS;
            tilt_ki_reg     <= '0;
            tilt_kd_reg     <= '0;
            filter_reg      <= 16'd62259;
            drive_limit_reg <= 31'd6553600;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_SPEED_KP:    speed_kp_reg    <= cfg_wdata;
                REG_SPEED_KI:    speed_ki_reg    <= cfg_wdata;
                REG_SPEED_KD:    speed_kd_reg    <= cfg_wdata;
                REG_TILT_KP:     tilt_kp_reg     <= cfg_wdata;
                REG_TILT_KI:     tilt_ki_reg     <= cfg_wdata;
                REG_TILT_KD:     tilt_kd_reg     <= cfg_wdata;
                REG_FILTER:      filter_reg      <= cfg_wdata[15:0];
                REG_DRIVE_LIMIT: drive_limit_reg <= cfg_wdata[30:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_tilt_reg <= '0;
            lms_reg       <= '0;
            ms_reg        <= '0;
            filt_reg      <= '0;
            si_reg        <= '0;
            sle_reg       <= '0;
            ti_reg        <= '0;
            tle_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            last_tilt_reg <= last_tilt_next;
            lms_reg       <= lms_next;
            ms_reg        <= ms_next;
            filt_reg      <= filt_next;
            si_reg        <= si_next;
            sle_reg       <= sle_next;
            ti_reg        <= ti_next;
            tle_reg       <= tle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tilt_reg     <= tilt_next;
        steer_reg    <= steer_next;
        thr_reg      <= thr_next;
        dt_reg       <= dt_next;
        dtilt_reg    <= dtilt_next;
        est_reg      <= est_next;
        err_reg      <= err_next;
        target_reg   <= target_next;
        drive_reg    <= drive_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        last_tilt_next = last_tilt_reg;
        lms_next       = lms_reg;
        ms_next        = ms_reg;
        filt_next      = filt_reg;
        si_next        = si_reg;
        sle_next       = sle_reg;
        ti_next        = ti_reg;
        tle_next       = tle_reg;
        tilt_next      = tilt_reg;
        steer_next     = steer_reg;
        thr_next       = thr_reg;
        dt_next        = dt_reg;
        dtilt_next     = dtilt_reg;
        est_next       = est_reg;
        err_next       = err_reg;
        target_next    = target_reg;
        drive_next     = drive_reg;
        acc_next       = acc_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_ctrl.start = 1'b0;
        div_ctrl.num   = 58'(err_reg - sle_reg) <<< DT_FRAC;
        div_ctrl.den   = dt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    tilt_next      = in_tilt;
                    steer_next     = s_tdata[111:96];
                    thr_next       = s_tdata[127:112];
                    dt_next        = s_tdata[159:128];
                    dtilt_next     = 33'(in_tilt) - 33'(last_tilt_reg);
                    last_tilt_next = in_tilt;
                    lms_next       = ms_reg;
                    ms_next        = 32'((33'(in_wl) + 33'(in_wr)) >>> 1);
                    if (s_tuser[0])
                    begin
                        si_next  = '0;
                        sle_next = '0;
                        ti_next  = '0;
                        tle_next = '0;
                    end
                    state_next = ST_ANG1;
                end
            end
            ST_ANG1:
            begin
                mul_a      = dtilt_reg;
                mul_b      = 33'sd90;
                state_next = ST_ANG2;
            end
            ST_ANG2:
            begin
                mul_a      = 33'(sat32(prod));
                mul_b      = {1'b0, dt_reg};
                state_next = ST_EST;
            end
            ST_EST:
            begin
                est_next   = sat32(-wide_t'(lms_reg) - wide_t'(sat32(prod_dt)));
                mul_a      = 33'(filt_reg);
                mul_b      = {17'd0, filter_reg};
                state_next = ST_FLT1;
            end
            ST_FLT1:
            begin
                acc_next   = prod;
                mul_a      = 33'(est_reg);
                mul_b      = 33'(17'h10000 - {1'b0, filter_reg});
                state_next = ST_FLT2;
            end
            ST_FLT2:
            begin
                filt_next  = 32'((acc_reg + prod) >>> 16);
                state_next = ST_SERR;
            end
            ST_SERR:
            begin
                err_next = sat32(clip((wide_t'(thr_reg) <<< FRAC_BITS) - wide_t'(filt_reg),
                                      ERR_LIM));
                state_next = ST_SINT0;
            end
            ST_SINT0:
            begin
                mul_a          = 33'(err_reg);
                mul_b          = {1'b0, dt_reg};
                div_ctrl.start = 1'b1;
                sle_next       = err_reg;
                state_next     = ST_SINT;
            end
            ST_SINT:
            begin
                si_next    = sat32(clip(wide_t'(si_reg) + prod_dt, INT_LIM));
                mul_a      = 33'(speed_kp_reg);
                mul_b      = 33'(err_reg);
                state_next = ST_SKP;
            end
            ST_SKP:
            begin
                acc_next   = prod_f;
                mul_a      = 33'(speed_ki_reg);
                mul_b      = 33'(si_reg);
                state_next = ST_SKI;
            end
            ST_SKI:
            begin
                acc_next   = acc_reg + prod_f;
                state_next = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                mul_a = 33'(speed_kd_reg);
                mul_b = 33'(q_sat);
                if (!div_stat.busy)
                    state_next = ST_SKD;
            end
            ST_SKD:
            begin
                target_next = sat32(clip(wide_t'(sat32(acc_reg + prod_f)), ANG_LIM));
                state_next  = ST_TERR;
            end
            ST_TERR:
            begin
                err_next   = sat32(wide_t'(target_reg) - wide_t'(tilt_reg));
                state_next = ST_TINT0;
            end
            ST_TINT0:
            begin
                mul_a          = 33'(err_reg);
                mul_b          = {1'b0, dt_reg};
                div_ctrl.start = 1'b1;
                div_ctrl.num   = 58'(err_reg - tle_reg) <<< DT_FRAC;
                tle_next       = err_reg;
                state_next     = ST_TINT;
            end
            ST_TINT:
            begin
                ti_next    = sat32(wide_t'(ti_reg) + prod_dt);
                mul_a      = 33'(tilt_kp_reg);
                mul_b      = 33'(err_reg);
                state_next = ST_TKP;
            end
            ST_TKP:
            begin
                acc_next   = prod_f;
                mul_a      = 33'(tilt_ki_reg);
                mul_b      = 33'(ti_reg);
                state_next = ST_TKI;
            end
            ST_TKI:
            begin
                acc_next   = acc_reg + prod_f;
                state_next = ST_TWAIT;
            end
            ST_TWAIT:
            begin
                mul_a = 33'(tilt_kd_reg);
                mul_b = 33'(q_sat);
                if (!div_stat.busy)
                    state_next = ST_TKD;
            end
            ST_TKD:
            begin
                drive_next = 32'(clip(wide_t'(sat32(acc_reg + prod_f)),
                                      wide_t'(drive_limit_reg)));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {target_reg,
                                      sat32(wide_t'(drive_reg) - st_w),
                                      sat32(wide_t'(drive_reg) + st_w)};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_ANG1))
        else $error("accepted transaction did not start a step");

    a_target_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (wide_t'($signed(m_tdata[95:64])) <= ANG_LIM &&
                      wide_t'($signed(m_tdata[95:64])) >= -ANG_LIM - wide_t'(1)))
        else $error("target tilt outside angle limit");

endmodule
`default_nettype wire

>>> design/cbp_mul.sv
// Shared signed 33x33 multiplier with registered product.
`default_nettype none
module cbp_mul (
    input  wire logic               clk,
    input  wire logic signed [32:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [65:0]      p
);
    import cbp_pkg::*;

    wide_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

>>> design/cbp_div.sv
// Bit-serial restoring divider for the derivative terms, truncating toward zero.
`default_nettype none
module cbp_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cbp_pkg::div_ctrl_t  ctrl,
    output cbp_pkg::div_stat_t       stat
);
    import cbp_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_MAG_W-1:0] mag_reg;
    logic [32:0]          rem_reg;
    logic [31:0]          den_reg;
    logic                 neg_reg;
    logic signed [57:0]   quo_reg;

    logic [32:0]          rem_sh;
    logic                 fits;
    logic [57:0]          num_abs;

    assign rem_sh  = {rem_reg[31:0], mag_reg[DIV_MAG_W-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign num_abs = ctrl.num[57] ? 58'(-ctrl.num) : 58'(ctrl.num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= ctrl.den != 32'd0;
            cnt_reg  <= DIV_CNT_W'(DIV_MAG_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mag_reg <= num_abs[DIV_MAG_W-1:0];
            rem_reg <= '0;
            den_reg <= ctrl.den;
            neg_reg <= ctrl.num[57];
            if (ctrl.den == 32'd0)
                quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            mag_reg <= {mag_reg[DIV_MAG_W-2:0], fits};
            if (cnt_reg == DIV_CNT_W'(1))
                quo_reg <= neg_reg ? -$signed({1'b0, mag_reg[DIV_MAG_W-2:0], fits})
                                   : $signed({1'b0, mag_reg[DIV_MAG_W-2:0], fits});
        end
    end

    assign stat.busy = busy_reg;
    assign stat.quo  = quo_reg;

endmodule
`default_nettype wire
